### hdl/bsa_pkg.sv
// Shared types and constants for the blocked bitmap slot allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package bsa_pkg;

  // Request and response field widths
  localparam int KIND_W   = 1;
  localparam int TYPE_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 1;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 1'b0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

  // Response status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic clear;        // write one clear-pass entry
    logic issue_new;    // take a new request from the input port, start the read
    logic issue_retry;  // re-issue the held request at the next block
    logic finish;       // write back the word and load the response register
    logic skip_block;   // current block is full: advance the type's search pointer
  } bsa_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic clear_last;   // clear pass is at its last entry
    logic block_full;   // allocate read a block with no free slot
    logic out_free;     // response register can take a beat this cycle
  } bsa_sts_t;

endpackage

`default_nettype wire

### hdl/bsa_ifs.sv
// Valid/ready channel interfaces for the allocator request and response.
// Depends on bsa_pkg for the field widths.
`default_nettype none

interface bsa_req_if;
  import bsa_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [TYPE_W-1:0]  heap_type;
  logic [INDEX_W-1:0] release_index;

  modport source (output valid, output kind, output heap_type, output release_index,
                  input ready);
  modport sink   (input valid, input kind, input heap_type, input release_index,
                  output ready);
endinterface

interface bsa_rsp_if;
  import bsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

### hdl/bsa_ctrl.sv
// Controller state machine of the slot allocator: clear pass, request intake,
// block search retries and response hand-off. Depends on bsa_pkg.
`default_nettype none

module bsa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire bsa_pkg::bsa_sts_t sts,
  output      bsa_pkg::bsa_cmd_t cmd
);
  import bsa_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RETRY = 4'b0100,
    ST_CHECK = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.issue_new = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_RETRY: begin
        cmd.issue_retry = 1'b1;
        state_next      = ST_CHECK;
      end
      ST_CHECK: begin
        // full block: move on; otherwise wait for room in the response register
        if (sts.block_full) begin
          cmd.skip_block = 1'b1;
          state_next     = ST_RETRY;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hdl/bsa_datapath.sv
// Datapath of the slot allocator: free-map memory, per-type search pointers,
// held request, lowest-free-slot encoder and response register. Depends on bsa_pkg.
`default_nettype none

module bsa_datapath #(
  parameter int SLOT_BITS       = 6,
  parameter int BLOCKS_PER_TYPE = 16,
  parameter int HEAP_TYPES      = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire bsa_pkg::bsa_cmd_t              cmd,
  output      bsa_pkg::bsa_sts_t              sts,
  input  wire logic [bsa_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [bsa_pkg::TYPE_W-1:0]     in_heap_type,
  input  wire logic [bsa_pkg::INDEX_W-1:0]    in_release_index,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [bsa_pkg::STATUS_W-1:0]   out_status,
  output      logic [bsa_pkg::INDEX_W-1:0]    out_slot_index
);
  import bsa_pkg::*;

  localparam int SW   = SLOT_BITS;
  localparam int WW   = 1 << SLOT_BITS;
  localparam int NUM  = HEAP_TYPES * BLOCKS_PER_TYPE;
  localparam int AW   = (NUM > 1) ? $clog2(NUM) : 1;
  localparam int HW   = $clog2(BLOCKS_PER_TYPE + 1);
  localparam int TW   = (HEAP_TYPES > 1) ? $clog2(HEAP_TYPES) : 1;
  localparam int RBW  = INDEX_W - SLOT_BITS;
  localparam int CW   = (RBW > HW) ? RBW : HW;
  localparam int IW   = HW + SW;

  localparam logic [3:0]    TYPES_C  = 4'(HEAP_TYPES);
  localparam logic [HW-1:0] BLOCKS_H = HW'(BLOCKS_PER_TYPE);
  localparam logic [CW-1:0] BLOCKS_C = CW'(BLOCKS_PER_TYPE);
  localparam logic [AW:0]   BLOCKS_A = (AW+1)'(BLOCKS_PER_TYPE);
  localparam logic [AW-1:0] LAST_A   = AW'(NUM - 1);

  // Lowest set bit by halving: one step per slot-index bit
  function automatic logic [SW-1:0] lowest_set(input logic [WW-1:0] v);
    logic [WW-1:0] rem;
    logic [WW-1:0] mask;
    logic [SW-1:0] idx;
    int            half;
    rem = v;
    idx = '0;
    for (int k = SW - 1; k >= 0; k--) begin
      half = 1 << k;
      mask = {WW{1'b1}} >> (WW - half);
      if ((rem & mask) == '0) begin
        idx[k] = 1'b1;
        rem    = rem >> half;
      end
    end
    return idx;
  endfunction

  logic [WW-1:0] mem [NUM];
  logic [WW-1:0] rdata;
  logic [AW-1:0] clr_addr;
  logic [HW-1:0] hint [HEAP_TYPES];

  // Held request
  logic [KIND_W-1:0]  req_kind;
  logic [TYPE_W-1:0]  req_type;
  logic [INDEX_W-1:0] req_index;
  logic               req_skip;
  logic [AW-1:0]      req_addr;
  logic [HW-1:0]      req_block;
  logic [SW-1:0]      req_slot;
  logic [TW-1:0]      req_t;

  // Issue-side decode
  logic               issue;
  logic [KIND_W-1:0]  src_kind;
  logic [TYPE_W-1:0]  src_type;
  logic [INDEX_W-1:0] src_index;
  logic [2:0]         type_x;
  logic [TW-1:0]      src_t;
  logic               type_ok;
  logic [HW-1:0]      hint_cur;
  logic [CW-1:0]      rel_blk_x;
  logic               blk_ok;
  logic [HW-1:0]      src_blk;
  logic               src_skip;
  logic [AW:0]        addr_x;
  logic [AW-1:0]      src_addr;

  // Finish-side decode
  logic               is_alloc;
  logic [SW-1:0]      alloc_slot;
  logic [SW-1:0]      slot_sel;
  logic [WW-1:0]      slot_bit;
  logic [WW-1:0]      wdata;
  logic [IW-1:0]      alloc_index;

  // Select the request source and form the memory address
  always_comb begin
    issue     = cmd.issue_new | cmd.issue_retry;
    src_kind  = cmd.issue_retry ? req_kind  : in_kind;
    src_type  = cmd.issue_retry ? req_type  : in_heap_type;
    src_index = cmd.issue_retry ? req_index : in_release_index;

    type_x    = {1'b0, src_type};
    src_t     = type_x[TW-1:0];
    type_ok   = 4'(src_type) < TYPES_C;
    hint_cur  = type_ok ? hint[src_t] : '0;

    rel_blk_x = CW'(src_index[INDEX_W-1:SLOT_BITS]);
    blk_ok    = rel_blk_x < BLOCKS_C;

    if (src_kind == KIND_ALLOC) begin
      src_blk  = hint_cur;
      src_skip = !type_ok || (hint_cur == BLOCKS_H);
    end else begin
      src_blk  = rel_blk_x[HW-1:0];
      src_skip = !type_ok || !blk_ok;
    end

    addr_x   = (AW+1)'(src_t) * BLOCKS_A + (AW+1)'(src_blk);
    src_addr = addr_x[AW-1:0];
  end

  // Capture the request at issue
  always_ff @(posedge clk) begin
    if (issue) begin
      req_kind  <= src_kind;
      req_type  <= src_type;
      req_index <= src_index;
      req_skip  <= src_skip;
      req_addr  <= src_addr;
      req_block <= src_blk;
      req_slot  <= src_index[SW-1:0];
      req_t     <= src_t;
    end
  end

  // Update the free map word
  always_comb begin
    is_alloc    = (req_kind == KIND_ALLOC);
    alloc_slot  = lowest_set(rdata);
    slot_sel    = is_alloc ? alloc_slot : req_slot;
    slot_bit    = WW'(1) << slot_sel;
    wdata       = is_alloc ? (rdata & ~slot_bit) : (rdata | slot_bit);
    alloc_index = {req_block, alloc_slot};
  end

  // Free-map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= '1;
    end else if (cmd.finish && !req_skip) begin
      mem[req_addr] <= wdata;
    end
    if (issue && !src_skip) begin
      rdata <= mem[src_addr];
    end
  end

  // Clear-pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && (clr_addr != LAST_A)) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Per-type search pointers: every block below the pointer is full
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HEAP_TYPES; i++) begin
        hint[i] <= '0;
      end
    end else if (cmd.skip_block) begin
      hint[req_t] <= req_block + HW'(1);
    end else if (cmd.finish && !req_skip) begin
      if (is_alloc) begin
        if (wdata == '0) begin
          hint[req_t] <= req_block + HW'(1);
        end
      end else if (req_block < hint[req_t]) begin
        hint[req_t] <= req_block;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status     <= (is_alloc && req_skip) ? STATUS_FULL : STATUS_DONE;
      out_slot_index <= (is_alloc && !req_skip) ? INDEX_W'(alloc_index) : '0;
    end
  end

  // Status to the controller
  always_comb begin
    sts.clear_last = (clr_addr == LAST_A);
    sts.block_full = is_alloc && !req_skip && (rdata == '0);
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

### hdl/blocked_bitmap_slot_allocator_unit.sv
// Blocked bitmap slot allocator: for each heap type a row of blocks, each block a free
// map of 2^SLOT_BITS slots held in a single-port-write, registered-read memory of
// HEAP_TYPES*BLOCKS_PER_TYPE words. An allocate returns (block << SLOT_BITS) | slot for
// the lowest free slot of the first block with room, or status full; a release frees the
// named slot and answers status done, index 0. After reset the block sweeps the memory
// to all-free, one word per cycle, and accepts no request meanwhile. One request is in
// flight at a time. A release, or an allocate whose type pointer already sits on a block
// with room, is read, then written back with the response loaded once the output register
// has room; each full block the allocate steps over adds a pointer step and another read.
// A per-type pointer marks the lowest block that may have room, so blocks that filled
// earlier are not read again until a release lands below the pointer. A new request is
// taken while the previous response still waits in the output register.
// Depends on bsa_pkg, bsa_ifs, bsa_ctrl and bsa_datapath.
`default_nettype none

module blocked_bitmap_slot_allocator_unit #(
  parameter int SLOT_BITS       = 6,
  parameter int BLOCKS_PER_TYPE = 16,
  parameter int HEAP_TYPES      = 4
) (
  input wire logic clk,
  input wire logic rst,
  bsa_req_if.sink  req,
  bsa_rsp_if.source rsp
);
  import bsa_pkg::*;

  bsa_cmd_t cmd;
  bsa_sts_t sts;
  logic     in_ready;

  assign req.ready = in_ready;

  // Controller
  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  bsa_datapath #(
    .SLOT_BITS       (SLOT_BITS),
    .BLOCKS_PER_TYPE (BLOCKS_PER_TYPE),
    .HEAP_TYPES      (HEAP_TYPES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (req.kind),
    .in_heap_type     (req.heap_type),
    .in_release_index (req.release_index),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .out_status       (rsp.status),
    .out_slot_index   (rsp.slot_index)
  );

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for blocked_bitmap_slot_allocator_unit.
// Drives allocate/release beats over the request channel, predicts every response
// from a private copy of the free maps, checks responses in order. Needs bsa_pkg, bsa_ifs.
`timescale 1ns / 100ps

import bsa_pkg::*;

typedef struct packed {
  logic [KIND_W-1:0]  kind;
  logic [TYPE_W-1:0]  heap_type;
  logic [INDEX_W-1:0] release_index;
} alloc_req_t;

typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  slot_index;
} alloc_rsp_t;

// Free-map predictor plus the in-order store of expected responses
class alloc_scoreboard #(int SLOT_BITS = 6, int BLOCKS = 16, int TYPES = 4);
  logic [63:0] free_map [TYPES][BLOCKS];
  logic [63:0] used_mask;
  alloc_rsp_t  expected_rsp [$];
  int          errors;

  function new();
    int t, b;
    used_mask = ((1 << SLOT_BITS) >= 64) ? '1 : ((64'd1 << (1 << SLOT_BITS)) - 64'd1);
    for (t = 0; t < TYPES; t++)
      for (b = 0; b < BLOCKS; b++)
        free_map[t][b] = used_mask;
    errors = 0;
  endfunction

  // Apply one request to the maps and return the response it must produce
  function alloc_rsp_t predict_response(alloc_req_t r);
    alloc_rsp_t res;
    logic [63:0] word;
    int blk, s;
    bit found;
    res.status = STATUS_DONE;
    res.slot_index = '0;
    found = 1'b0;
    if (r.kind == KIND_ALLOC) begin
      if (int'(r.heap_type) < TYPES) begin
        for (blk = 0; blk < BLOCKS && !found; blk++) begin
          word = free_map[r.heap_type][blk] & used_mask;
          if (word != '0) begin
            s = 0;
            while (!word[s]) s++;
            free_map[r.heap_type][blk] = word & ~(64'd1 << s);
            res.slot_index = INDEX_W'((blk << SLOT_BITS) | s);
            found = 1'b1;
          end
        end
      end
      if (!found) res.status = STATUS_FULL;
    end else begin
      blk = int'(r.release_index) >> SLOT_BITS;
      s = int'(r.release_index) & ((1 << SLOT_BITS) - 1);
      if (int'(r.heap_type) < TYPES && blk < BLOCKS)
        free_map[r.heap_type][blk] = (free_map[r.heap_type][blk] | (64'd1 << s)) & used_mask;
    end
    return res;
  endfunction

  function alloc_rsp_t note_request(alloc_req_t r);
    alloc_rsp_t res;
    res = predict_response(r);
    expected_rsp.insert(expected_rsp.size(), res);
    return res;
  endfunction

  function void check_response(alloc_rsp_t got);
    alloc_rsp_t exp;
    if (expected_rsp.size() == 0) begin
      errors++;
      $display("%0t: unexpected response, expected none, actual status %0d index %0d",
               $time, got.status, got.slot_index);
    end else begin
      exp = expected_rsp.pop_front();
      if (got.status !== exp.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, exp.status, got.status);
      end
      if (got.slot_index !== exp.slot_index) begin
        errors++;
        $display("%0t: slot_index mismatch, expected %0d, actual %0d",
                 $time, exp.slot_index, got.slot_index);
      end
    end
  endfunction

  function int pending();
    return expected_rsp.size();
  endfunction
endclass

module testbench;
  localparam int SLOT_BITS       = 6;
  localparam int BLOCKS_PER_TYPE = 16;
  localparam int HEAP_TYPES      = 4;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int DRAIN_CYCLES    = 40;

  logic clk;
  logic rst;

  bsa_req_if req_ch ();
  bsa_rsp_if rsp_ch ();

  blocked_bitmap_slot_allocator_unit #(
    .SLOT_BITS       (SLOT_BITS),
    .BLOCKS_PER_TYPE (BLOCKS_PER_TYPE),
    .HEAP_TYPES      (HEAP_TYPES)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  alloc_scoreboard #(SLOT_BITS, BLOCKS_PER_TYPE, HEAP_TYPES) sb;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int full_count;
  int cycles;
  logic [INDEX_W-1:0] held_slots [HEAP_TYPES][$];

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Response side: check accepted beats, then pick ready for the next cycle
  initial begin : rsp_side
    int hold_left;
    alloc_rsp_t got;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.slot_index = rsp_ch.slot_index;
        sb.check_response(got);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !rst && !chance(recv_stall_pct);
      end
    end
  end

  // Offer one beat until accepted; valid stays high afterwards until the next gap
  task automatic send_request(input alloc_req_t r);
    alloc_rsp_t exp;
    while (chance(send_idle_pct)) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= r.kind;
    req_ch.heap_type <= r.heap_type;
    req_ch.release_index <= r.release_index;
    do @(posedge clk); while (!req_ch.ready);
    exp = sb.note_request(r);
    if (r.kind == KIND_ALLOC && exp.status == STATUS_DONE)
      held_slots[r.heap_type].insert(held_slots[r.heap_type].size(), exp.slot_index);
    if (exp.status == STATUS_FULL) full_count++;
  endtask

  task automatic send_fields(input logic [KIND_W-1:0] k, input int t, input int idx);
    alloc_req_t r;
    r.kind = k;
    r.heap_type = TYPE_W'(t);
    r.release_index = INDEX_W'(idx);
    send_request(r);
  endtask

  // Release one slot that this type holds, picked at random
  task automatic release_held(input int t);
    int pick;
    logic [INDEX_W-1:0] idx;
    pick = $urandom_range(held_slots[t].size() - 1);
    idx = held_slots[t][pick];
    held_slots[t].delete(pick);
    send_fields(KIND_RELEASE, t, idx);
  endtask

  // Mostly allocates and releases of held slots; some releases of arbitrary slots
  task automatic random_request();
    int t;
    t = $urandom_range(HEAP_TYPES - 1);
    if (chance(55))
      send_fields(KIND_ALLOC, t, $urandom_range(1023));
    else if (held_slots[t].size() > 0 && chance(75))
      release_held(t);
    else
      send_fields(KIND_RELEASE, t, $urandom_range(1023));
  endtask

  task automatic random_phase(input int n, input int idle_pct, input int stall_pct);
    int i;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < n; i++) random_request();
  endtask

  // Drive one type to full, see several full answers, then free held slots at random and reuse them
  task automatic fill_phase();
    int ft, i;
    ft = $urandom_range(HEAP_TYPES - 1);
    full_count = 0;
    send_idle_pct = 13;
    recv_stall_pct = 13;
    while (full_count < 6) begin
      if (chance(92)) send_fields(KIND_ALLOC, ft, $urandom_range(1023));
      else random_request();
    end
    for (i = 0; i < 80; i++) begin
      if (held_slots[ft].size() > 0 && chance(55)) release_held(ft);
      else send_fields(KIND_ALLOC, ft, $urandom_range(1023));
    end
  endtask

  initial begin : stimulus
    sb = new();
    hold_request = 0;
    full_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_ALLOC;
    req_ch.heap_type = '0;
    req_ch.release_index = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: each type, reuse of the lowest slot, double release, index extremes
    send_fields(KIND_ALLOC, 0, 0);
    send_fields(KIND_ALLOC, 0, 1023);
    send_fields(KIND_ALLOC, 1, 0);
    send_fields(KIND_ALLOC, 2, 0);
    send_fields(KIND_ALLOC, 3, 0);
    send_fields(KIND_RELEASE, 0, 0);
    send_fields(KIND_ALLOC, 0, 0);
    send_fields(KIND_RELEASE, 0, 1);
    send_fields(KIND_RELEASE, 0, 1);
    send_fields(KIND_RELEASE, 1, 1023);
    send_fields(KIND_RELEASE, 3, 0);
    send_fields(KIND_ALLOC, 3, 0);
    send_fields(KIND_RELEASE, 2, 'h2AA);
    send_fields(KIND_RELEASE, 2, 'h155);
    send_fields(KIND_ALLOC, 2, 'h3FF);
    send_fields(KIND_ALLOC, 1, 'h155);
    for (int t = 0; t < HEAP_TYPES; t++) held_slots[t].delete();
    send_fields(KIND_RELEASE, 0, 0);
    send_fields(KIND_RELEASE, 1, 0);
    send_fields(KIND_RELEASE, 2, 0);
    send_fields(KIND_RELEASE, 3, 0);
    send_fields(KIND_RELEASE, 2, 1);
    send_fields(KIND_RELEASE, 1, 1);

    // Random phases under different idle patterns
    random_phase(110, 0, 0);
    random_phase(110, 82, 0);
    random_phase(110, 0, 82);
    random_phase(110, 13, 13);

    // Long receiver hold while the sender keeps offering beats
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 300;
    for (int i = 0; i < 40; i++) random_request();

    fill_phase();
    random_phase(60, 13, 13);

    // Drain
    req_ch.valid <= 1'b0;
    recv_stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

### sim.f
hdl/bsa_pkg.sv
hdl/bsa_ifs.sv
hdl/bsa_ctrl.sv
hdl/bsa_datapath.sv
hdl/blocked_bitmap_slot_allocator_unit.sv
sim/testbench.sv
